// ===== design/pls_pkg.sv =====
// Shared types and constants for the positional list store.
// Used by pls_cell, pls_ctrl, positional_list_store and pls_checker; no dependencies.
package pls_pkg;

	localparam int CAPACITY = 32;
	localparam int VAL_W    = 32;
	localparam int POS_W    = 6;
	localparam int COUNT_W  = 6;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam int REQ_W    = 3;
	localparam int STAT_W   = 2;
	localparam int IN_TDATA_W  = ((VAL_W + POS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((VAL_W + COUNT_W + 7) / 8) * 8;

	typedef enum logic [REQ_W-1:0] {
		REQ_INS_FRONT = 3'd0,
		REQ_INS_BACK  = 3'd1,
		REQ_INS_AT    = 3'd2,
		REQ_DEL_FRONT = 3'd3,
		REQ_DEL_BACK  = 3'd4,
		REQ_DEL_AT    = 3'd5,
		REQ_DUMP      = 3'd6
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_FULL    = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		C_HOLD = 2'd0,
		C_INS  = 2'd1,
		C_DEL  = 2'd2,
		C_ROT  = 2'd3
	} cell_op_t;

	// Broadcast to every cell of the chain
	typedef struct packed {
		cell_op_t               op;
		logic [IDX_W-1:0]       pos;
		logic [IDX_W-1:0]       tail;
		logic [VAL_W-1:0]       value;
	} cell_ctl_t;

endpackage

// ===== design/pls_cell.sv =====
// One storage cell of the list chain: holds one element, takes a new value, a neighbor's or the front one's.
// Depends on pls_pkg.
module pls_cell (
	input  logic                          clk,
	input  pls_pkg::cell_ctl_t            ctl,
	input  logic [pls_pkg::IDX_W-1:0]     my_idx,
	input  logic [pls_pkg::VAL_W-1:0]     left_d,
	input  logic [pls_pkg::VAL_W-1:0]     right_d,
	input  logic [pls_pkg::VAL_W-1:0]     first_d,
	output logic [pls_pkg::VAL_W-1:0]     data_q
);

	logic [pls_pkg::VAL_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		unique case (ctl.op)
			pls_pkg::C_HOLD: data_d = data_q;
			pls_pkg::C_INS: begin
				if (my_idx == ctl.pos) data_d = ctl.value;
				else if (my_idx > ctl.pos) data_d = left_d;
			end
			pls_pkg::C_DEL: begin
				if (my_idx >= ctl.pos) data_d = right_d;
			end
			pls_pkg::C_ROT: begin
				// front element wraps to the tail, the rest move one toward the front
				if (my_idx == ctl.tail) data_d = first_d;
				else data_d = right_d;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

// ===== design/pls_ctrl.sv =====
// Request decoder and sequencer: element count, dump walk, output register.
// Depends on pls_pkg; drives the cell chain of positional_list_store.
module pls_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [pls_pkg::REQ_W-1:0]         in_req,
	input  logic [pls_pkg::VAL_W-1:0]         in_value,
	input  logic [pls_pkg::POS_W-1:0]         in_pos,
	input  logic [pls_pkg::VAL_W-1:0]         head_d,
	output pls_pkg::cell_ctl_t                ctl,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pls_pkg::STAT_W-1:0]        out_status,
	output logic [pls_pkg::VAL_W-1:0]         out_value,
	output logic [pls_pkg::COUNT_W-1:0]       out_count,
	output logic                              out_last
);

	typedef enum logic {S_IDLE, S_DUMP} state_t;

	state_t                         state_q;
	logic [pls_pkg::CNT_W-1:0]      count_q;
	logic [pls_pkg::CNT_W-1:0]      left_q;
	logic                           valid_q;
	pls_pkg::status_t               status_q;
	logic [pls_pkg::VAL_W-1:0]      value_q;
	logic                           last_q;

	logic                           out_free;
	logic                           take;
	logic                           emit;
	pls_pkg::status_t               status_c;
	logic [pls_pkg::CNT_W-1:0]      count_c;
	logic                           dump_start;
	logic                           full;
	logic                           empty;
	logic [pls_pkg::CMP_W-1:0]      pos_w;
	logic [pls_pkg::CMP_W-1:0]      cnt_w;

	assign out_free = !valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign take     = in_valid && in_ready;
	assign emit     = (state_q == S_DUMP) && out_free;
	assign full     = (count_q == pls_pkg::CNT_W'(pls_pkg::CAPACITY));
	assign empty    = (count_q == '0);
	assign pos_w    = pls_pkg::CMP_W'(in_pos);
	assign cnt_w    = pls_pkg::CMP_W'(count_q);

	always_comb begin
		ctl.op     = pls_pkg::C_HOLD;
		ctl.pos    = pls_pkg::IDX_W'(in_pos - pls_pkg::POS_W'(1));
		ctl.tail   = pls_pkg::IDX_W'(count_q - pls_pkg::CNT_W'(1));
		ctl.value  = in_value;
		status_c   = pls_pkg::ST_OK;
		count_c    = count_q;
		dump_start = 1'b0;
		if (take) begin
			unique case (pls_pkg::req_t'(in_req))
				pls_pkg::REQ_INS_FRONT: begin
					if (full) status_c = pls_pkg::ST_FULL;
					else begin
						ctl.op  = pls_pkg::C_INS;
						ctl.pos = '0;
						count_c = count_q + pls_pkg::CNT_W'(1);
					end
				end
				pls_pkg::REQ_INS_BACK: begin
					if (full) status_c = pls_pkg::ST_FULL;
					else begin
						ctl.op  = pls_pkg::C_INS;
						ctl.pos = pls_pkg::IDX_W'(count_q);
						count_c = count_q + pls_pkg::CNT_W'(1);
					end
				end
				pls_pkg::REQ_INS_AT: begin
					if (pos_w == '0 || pos_w > cnt_w + pls_pkg::CMP_W'(1))
						status_c = pls_pkg::ST_BAD_POS;
					else if (full) status_c = pls_pkg::ST_FULL;
					else begin
						ctl.op  = pls_pkg::C_INS;
						count_c = count_q + pls_pkg::CNT_W'(1);
					end
				end
				pls_pkg::REQ_DEL_FRONT: begin
					if (empty) status_c = pls_pkg::ST_EMPTY;
					else begin
						ctl.op  = pls_pkg::C_DEL;
						ctl.pos = '0;
						count_c = count_q - pls_pkg::CNT_W'(1);
					end
				end
				pls_pkg::REQ_DEL_BACK: begin
					if (empty) status_c = pls_pkg::ST_EMPTY;
					else begin
						// nothing past the tail is read, so no cell needs to move
						count_c = count_q - pls_pkg::CNT_W'(1);
					end
				end
				pls_pkg::REQ_DEL_AT: begin
					if (pos_w == '0 || pos_w > cnt_w) status_c = pls_pkg::ST_BAD_POS;
					else begin
						ctl.op  = pls_pkg::C_DEL;
						count_c = count_q - pls_pkg::CNT_W'(1);
					end
				end
				pls_pkg::REQ_DUMP: begin
					if (empty) status_c = pls_pkg::ST_EMPTY;
					else dump_start = 1'b1;
				end
				default: status_c = pls_pkg::ST_OK;
			endcase
		end else if (emit) begin
			ctl.op = pls_pkg::C_ROT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			left_q   <= '0;
			valid_q  <= 1'b0;
			status_q <= pls_pkg::ST_OK;
			value_q  <= '0;
			last_q   <= 1'b0;
		end else begin
			count_q <= count_c;
			unique case (state_q)
				S_IDLE: begin
					if (take && dump_start) begin
						state_q <= S_DUMP;
						left_q  <= count_q;
						if (out_ready) valid_q <= 1'b0;
					end else if (take) begin
						valid_q  <= 1'b1;
						status_q <= status_c;
						value_q  <= '0;
						last_q   <= 1'b1;
					end else if (out_ready) begin
						valid_q <= 1'b0;
					end
				end
				S_DUMP: begin
					if (emit) begin
						// head of the ring goes out while the chain rotates
						valid_q  <= 1'b1;
						status_q <= pls_pkg::ST_OK;
						value_q  <= head_d;
						last_q   <= (left_q == pls_pkg::CNT_W'(1));
						left_q   <= left_q - pls_pkg::CNT_W'(1);
						if (left_q == pls_pkg::CNT_W'(1)) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = valid_q;
	assign out_status = status_q;
	assign out_value  = value_q;
	assign out_count  = pls_pkg::COUNT_W'(count_q);
	assign out_last   = last_q;

endmodule

// ===== design/positional_list_store.sv =====
// Top level of the positional list store: sequencer plus a chain of element cells.
// Depends on pls_pkg, pls_ctrl and pls_cell.

// Keeps an ordered list of up to CAPACITY signed 32-bit values in a chain of cells that
// shift in parallel. Every update (insert or delete at front, back or a 1-based position)
// returns one item with last set. A dump of n elements returns n items: the request is
// registered into the dump state, and each item is then registered from the front cell,
// one per cycle while the output is not stalled, as the chain rotates its front element
// to the tail, so the input stays closed until the last item is registered. An empty dump
// returns one item with status empty. A new request is taken only in a cycle where the
// output register is empty or its item is being taken, so a stalled result holds the input.
// Cells need no clearing after reset: only cells below the element count are ever read.
module positional_list_store (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [pls_pkg::IN_TDATA_W-1:0]      s_tdata,  // value[31:0], position[37:32]
	input  logic [pls_pkg::REQ_W-1:0]           s_tuser,  // req_type[2:0]
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [pls_pkg::OUT_TDATA_W-1:0]     m_tdata,  // elem_value[31:0], elem_count[37:32]
	output logic [pls_pkg::STAT_W-1:0]          m_tuser,  // status[1:0]
	output logic                                m_tlast
);

	localparam int N = pls_pkg::CAPACITY;

	pls_pkg::cell_ctl_t                 ctl;
	logic [pls_pkg::VAL_W-1:0]          cell_q [N];
	logic [pls_pkg::VAL_W-1:0]          out_value;
	logic [pls_pkg::COUNT_W-1:0]        out_count;

	pls_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_req     (s_tuser),
		.in_value   (s_tdata[pls_pkg::VAL_W-1:0]),
		.in_pos     (s_tdata[pls_pkg::VAL_W +: pls_pkg::POS_W]),
		.head_d     (cell_q[0]),
		.ctl        (ctl),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_value  (out_value),
		.out_count  (out_count),
		.out_last   (m_tlast)
	);

	for (genvar g = 0; g < N; g++) begin : g_cell
		logic [pls_pkg::VAL_W-1:0] left_d;
		logic [pls_pkg::VAL_W-1:0] right_d;
		if (g == 0) begin : g_first
			assign left_d = cell_q[g];
		end else begin : g_mid
			assign left_d = cell_q[g-1];
		end
		if (g == N - 1) begin : g_end
			assign right_d = cell_q[g];
		end else begin : g_inner
			assign right_d = cell_q[g+1];
		end
		pls_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.my_idx  (pls_pkg::IDX_W'(g)),
			.left_d  (left_d),
			.right_d (right_d),
			.first_d (cell_q[0]),
			.data_q  (cell_q[g])
		);
	end

	assign m_tdata = pls_pkg::OUT_TDATA_W'({out_count, out_value});

endmodule

// ===== design/pls_checker.sv =====
// Port-level checks for positional_list_store, bound to the top level.
// Depends on pls_pkg and positional_list_store.
module pls_port_checks (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tready,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [pls_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic [pls_pkg::STAT_W-1:0]          m_tuser,
	input  logic                                m_tlast
);

	// stalled item holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	// a failed request gives exactly one item
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != pls_pkg::ST_OK |-> m_tlast && m_tdata[pls_pkg::VAL_W-1:0] == '0)
		else $error("error item not single or carries a value");

	// a dump in progress keeps the input closed
	a_dump_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("request taken in the middle of a dump");

	// a dump streams without gaps once the consumer takes an item
	a_dump_next: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside a dump");

endmodule

bind positional_list_store pls_port_checks u_pls_port_checks (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ===== sim/pls_checker.sv =====
// Checker for the positional list store: watches both stream channels and predicts results.
// Depends on pls_pkg; instantiated by tb beside the block.
`timescale 1ns / 1ps

module pls_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic [pls_pkg::IN_TDATA_W-1:0]      s_tdata,  // value[31:0], position[37:32]
	input  logic [pls_pkg::REQ_W-1:0]           s_tuser,  // req_type[2:0]
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [pls_pkg::OUT_TDATA_W-1:0]     m_tdata,  // elem_value[31:0], elem_count[37:32]
	input  logic [pls_pkg::STAT_W-1:0]          m_tuser,  // status[1:0]
	input  logic                                m_tlast,
	output int                                  mismatches,
	output int                                  outstanding,
	output int                                  list_len
);

	typedef struct packed {
		pls_pkg::status_t                  status;
		logic [pls_pkg::VAL_W-1:0]         value;
		logic [pls_pkg::COUNT_W-1:0]       count;
		logic                              last;
	} list_item_t;

	list_item_t                  awaited[$];
	logic [pls_pkg::VAL_W-1:0]   cells[pls_pkg::CAPACITY];
	int                          len = 0;

	initial begin
		mismatches  = 0;
		outstanding = 0;
		list_len    = 0;
	end

	function automatic list_item_t make_item(pls_pkg::status_t st, logic [31:0] v, logic last);
		list_item_t it;
		it.status = st;
		it.value  = v;
		it.count  = len[pls_pkg::COUNT_W-1:0];
		it.last   = last;
		return it;
	endfunction

	// Open a gap at idx by shifting the tail back one cell and store v there, or report full
	task automatic place(input int idx, input logic [31:0] v, output pls_pkg::status_t st);
		if (len >= pls_pkg::CAPACITY) begin
			st = pls_pkg::ST_FULL;
		end else begin
			for (int i = len; i > idx; i--)
				cells[i] = cells[i-1];
			cells[idx] = v;
			len++;
			st = pls_pkg::ST_OK;
		end
	endtask

	task automatic remove(input int idx);
		for (int i = idx; i + 1 < len; i++)
			cells[i] = cells[i+1];
		len--;
	endtask

	task automatic predict_request(input logic [2:0] kind, input logic [31:0] v,
			input logic [5:0] pos);
		pls_pkg::status_t st;
		st = pls_pkg::ST_OK;
		case (kind)
			pls_pkg::REQ_INS_FRONT: place(0, v, st);
			pls_pkg::REQ_INS_BACK:  place(len, v, st);
			pls_pkg::REQ_INS_AT: begin
				// position check wins over the full check
				if (pos < 1 || pos > len + 1)
					st = pls_pkg::ST_BAD_POS;
				else
					place(pos - 1, v, st);
			end
			pls_pkg::REQ_DEL_FRONT: begin
				if (len == 0) st = pls_pkg::ST_EMPTY;
				else remove(0);
			end
			pls_pkg::REQ_DEL_BACK: begin
				if (len == 0) st = pls_pkg::ST_EMPTY;
				else remove(len - 1);
			end
			pls_pkg::REQ_DEL_AT: begin
				if (pos < 1 || pos > len) st = pls_pkg::ST_BAD_POS;
				else remove(pos - 1);
			end
			pls_pkg::REQ_DUMP: begin
				if (len == 0) st = pls_pkg::ST_EMPTY;
				else begin
					for (int i = 0; i < len; i++)
						awaited.push_back(make_item(pls_pkg::ST_OK, cells[i], i == len - 1));
					return;
				end
			end
			default: st = pls_pkg::ST_OK;
		endcase
		awaited.push_back(make_item(st, '0, 1'b1));
	endtask

	task automatic flag(input string field, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		list_item_t want;
		if (arst_n) begin
			// compare before predicting: a result never belongs to the item taken this edge
			if (m_tvalid && m_tready) begin
				if (awaited.size() == 0) begin
					$display("%0t: unexpected item, expected none, actual %h/%h/%b", $time,
						m_tuser, m_tdata, m_tlast);
					mismatches++;
				end else begin
					want = awaited.pop_front();
					flag("status", 32'(want.status), 32'(m_tuser));
					flag("elem_value", want.value, m_tdata[pls_pkg::VAL_W-1:0]);
					flag("elem_count", 32'(want.count),
						32'(m_tdata[pls_pkg::VAL_W +: pls_pkg::COUNT_W]));
					flag("last", 32'(want.last), 32'(m_tlast));
				end
			end
			if (s_tvalid && s_tready)
				predict_request(s_tuser, s_tdata[pls_pkg::VAL_W-1:0],
					s_tdata[pls_pkg::VAL_W +: pls_pkg::POS_W]);
			outstanding = awaited.size();
			list_len    = len;
		end
	end

endmodule

// ===== sim/tb.sv =====
// Top of the positional list store regression: clock, reset, stimulus and verdict.
// Depends on pls_pkg, positional_list_store and pls_checker.
`timescale 1ns / 1ps

module tb;

	localparam logic [2:0] REQ_UNUSED = 3'd7;

	logic                                clk;
	logic                                arst_n;
	logic                                s_tvalid;
	logic                                s_tready;
	logic [pls_pkg::IN_TDATA_W-1:0]      s_tdata;
	logic [pls_pkg::REQ_W-1:0]           s_tuser;
	logic                                m_tvalid;
	logic                                m_tready;
	logic [pls_pkg::OUT_TDATA_W-1:0]     m_tdata;
	logic [pls_pkg::STAT_W-1:0]          m_tuser;
	logic                                m_tlast;

	int mismatches;
	int outstanding;
	int list_len;
	int burst_left = 0;

	positional_list_store dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	pls_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.list_len    (list_len)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Called at a falling edge; returns at the falling edge after the item is taken, or later after a random idle gap
	task automatic send(input logic [2:0] kind, input logic [31:0] v, input logic [5:0] pos);
		s_tvalid = 1'b1;
		s_tuser  = kind;
		s_tdata  = {{(pls_pkg::IN_TDATA_W - pls_pkg::VAL_W - pls_pkg::POS_W){1'b0}}, pos, v};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(0, 15);
		end
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	initial begin
		int          target;
		int          r;
		logic [2:0]  kind;
		logic [31:0] v;
		logic [5:0]  pos;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		target   = pls_pkg::CAPACITY;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		burst_left = 40;

		// empty-store corner cases
		send(pls_pkg::REQ_DUMP,      32'h0, 6'd0);
		send(pls_pkg::REQ_DEL_FRONT, 32'h0, 6'd0);
		send(pls_pkg::REQ_DEL_BACK,  32'h0, 6'd0);
		send(pls_pkg::REQ_DEL_AT,    32'h0, 6'd1);
		send(pls_pkg::REQ_INS_AT,    32'h1234_5678, 6'd0);
		send(pls_pkg::REQ_INS_AT,    32'h1234_5678, 6'd2);
		// build four elements from the value extremes
		send(pls_pkg::REQ_INS_FRONT, 32'h7fff_ffff, 6'd63);
		send(pls_pkg::REQ_INS_BACK,  32'h8000_0000, 6'd0);
		send(pls_pkg::REQ_INS_AT,    32'h0, 6'd3);
		send(pls_pkg::REQ_INS_AT,    32'hffff_ffff, 6'd1);
		send(pls_pkg::REQ_INS_AT,    32'h5555_aaaa, 6'd63);
		send(REQ_UNUSED,             32'hffff_ffff, 6'd63);
		send(pls_pkg::REQ_DUMP,      32'hffff_ffff, 6'd63);
		// delete position bounds, then drain
		send(pls_pkg::REQ_DEL_AT,    32'h0, 6'd5);
		send(pls_pkg::REQ_DEL_AT,    32'h0, 6'd0);
		send(pls_pkg::REQ_DEL_AT,    32'h0, 6'd2);
		send(pls_pkg::REQ_DEL_AT,    32'h0, 6'd63);
		send(pls_pkg::REQ_DEL_FRONT, 32'h0, 6'd0);
		send(pls_pkg::REQ_DEL_BACK,  32'h0, 6'd0);
		send(pls_pkg::REQ_DUMP,      32'h0, 6'd0);
		send(pls_pkg::REQ_DEL_AT,    32'h0, 6'd1);
		send(pls_pkg::REQ_DUMP,      32'h0, 6'd0);
		wait_drained();
		@(negedge clk);

		for (int n = 0; n < 448; n++) begin
			// steer the fill level between empty and full
			if ($urandom_range(0, 29) == 0) begin
				case ($urandom_range(0, 3))
					0:       target = 0;
					1, 2:    target = pls_pkg::CAPACITY;
					default: target = $urandom_range(0, pls_pkg::CAPACITY);
				endcase
			end
			v = ($urandom_range(0, 9) == 0)
				? ($urandom_range(0, 1) ? {$urandom_range(0, 1) ? 1'b1 : 1'b0, {31{1'b0}}}
					: {$urandom_range(0, 1) ? 1'b1 : 1'b0, {31{1'b1}}})
				: $urandom;
			r = $urandom_range(0, 99);
			if (r < 8) begin
				kind = pls_pkg::REQ_DUMP;
				pos  = 6'($urandom_range(0, 63));
			end else if (r < 15) begin
				// broken request: any code, any position
				kind = 3'($urandom_range(0, 7));
				pos  = 6'($urandom_range(0, 63));
			end else if (list_len == 0 || list_len < target
					|| (list_len == target && $urandom_range(0, 1) == 0)) begin
				kind = 3'($urandom_range(pls_pkg::REQ_INS_FRONT, pls_pkg::REQ_INS_AT));
				pos  = 6'($urandom_range(1, list_len + 1));
			end else begin
				kind = 3'($urandom_range(pls_pkg::REQ_DEL_FRONT, pls_pkg::REQ_DEL_AT));
				pos  = 6'($urandom_range(1, list_len));
			end
			send(kind, v, pos);
			if ($urandom_range(0, 59) == 0) begin
				wait_drained();
				@(negedge clk);
			end
		end

		wait_drained();
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("positional_list_store regression: pass");
		else
			$display("positional_list_store regression: fail");
		$finish;
	end

	// Receiver: long hold-off first so the block backs up, then mixed stall patterns
	initial begin
		int mode;
		int span;
		m_tready = 1'b0;
		@(posedge arst_n);
		repeat (100) @(negedge clk);
		forever begin
			mode = $urandom_range(0, 4);
			span = $urandom_range(4, 40);
			if ($urandom_range(0, 60) == 0) begin
				repeat (120) begin
					@(negedge clk);
					m_tready = 1'b0;
				end
			end
			for (int c = 0; c < span; c++) begin
				@(negedge clk);
				case (mode)
					0:       m_tready = 1'b1;
					1:       m_tready = 1'($urandom_range(0, 1));
					2:       m_tready = ($urandom_range(0, 3) != 0);
					3:       m_tready = (c % 5 == 4);
					default: m_tready = (c % 3 != 0);
				endcase
			end
		end
	end

	initial begin
		#2_000_000;
		$display("positional_list_store regression: fail");
		$finish;
	end

endmodule
